@@ sv/psvs_pkg.sv @@
package psvs_pkg;

    localparam int VOICES_DEFAULT = 4;

    localparam int NOTE_W   = 7;
    localparam int PERIOD_W = 16;
    localparam int DIV_W    = 8;
    localparam int FUNC_W   = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    localparam logic [DIV_W-1:0] DUTY_DIVISOR_RESET = 8'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_NOTE_ON  = 2'd1,
        FUNC_NOTE_OFF = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TICK = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_OFF  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

@@ sv/polyphonic_square_voice_synth_core.sv @@
// Polyphonic square-wave tone generator with a pool of VOICES voices. Each input beat
// carries a function in s_tuser: a sample tick returns one beat with the speaker level,
// while note on and note off return nothing. The block takes one beat at a time and a
// single sequencer visits the voices one per cycle. After the sweep, a note on runs a
// bit-serial divider that yields one quotient bit per cycle and forms the high time as
// period / duty_divisor. A note on whose note already sounds, or that finds no free
// voice, ends after the sweep without the divider. A note on or note off with note zero,
// or a beat with the unused function, goes straight back to idle.
// A finished tick result waits in the output register until it is taken, and the next
// tick result holds the block until that register is free. The user must write the
// divisor through cfg_we and cfg_wdata while the block is idle; the block does not
// enforce this. A divisor of zero acts as one.
module polyphonic_square_voice_synth_core #(
    parameter int VOICES = psvs_pkg::VOICES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: note [6:0], note_period [22:7], zero fill [23].
    input  logic [psvs_pkg::S_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: func [1:0].
    input  logic [psvs_pkg::FUNC_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: speaker [0], zero fill [7:1].
    output logic [psvs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [psvs_pkg::DIV_W-1:0]     cfg_wdata
);
    import psvs_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    state_t                state_reg, state_next;
    logic [DIV_W-1:0]      divisor_reg;
    logic [NOTE_W-1:0]     note_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [VW-1:0]         vidx_reg, vidx_next;
    logic                  dup_reg, dup_next;
    logic                  free_found_reg, free_found_next;
    logic [VW-1:0]         free_idx_reg, free_idx_next;
    logic                  level_reg, level_next;
    logic [PERIOD_W-1:0]   quot_reg, quot_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  speaker_reg, speaker_next;

    logic [NOTE_W-1:0]     voice_note_reg   [VOICES];
    logic [PERIOD_W-1:0]   voice_period_reg [VOICES];
    logic [PERIOD_W-1:0]   voice_duty_reg   [VOICES];
    logic [PERIOD_W-1:0]   voice_phase_reg  [VOICES];

    logic                  accept;
    logic                  last_voice;
    logic [NOTE_W-1:0]     cur_note;
    logic [PERIOD_W:0]     phase_inc;
    logic [PERIOD_W-1:0]   phase_wrap;
    logic                  cur_high;
    logic [DIV_W-1:0]      div_eff;
    logic [DIV_W:0]        rem_shift;
    logic                  q_bit;
    logic                  out_free;
    logic                  write_tick, write_on, write_off;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {{(M_DATA_W-1){1'b0}}, speaker_reg};
    assign out_free   = !m_valid_reg || m_tready;
    assign last_voice = (vidx_reg == LAST_VOICE);

    assign cur_note   = voice_note_reg[vidx_reg];
    assign cur_high   = voice_phase_reg[vidx_reg] < voice_duty_reg[vidx_reg];
    assign phase_inc  = {1'b0, voice_phase_reg[vidx_reg]} + 17'd1;
    assign phase_wrap = (phase_inc >= {1'b0, voice_period_reg[vidx_reg]}) ?
                        '0 : phase_inc[PERIOD_W-1:0];

    assign div_eff    = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
    assign rem_shift  = {rem_reg, quot_reg[PERIOD_W-1]};
    assign q_bit      = (rem_shift >= {1'b0, div_eff});

    assign write_tick = (state_reg == ST_TICK) && (cur_note != '0);
    assign write_off  = (state_reg == ST_OFF) && (cur_note == note_reg);
    assign write_on   = (state_reg == ST_DIV) && (cnt_reg == 4'd15);

    always_comb begin
        state_next      = state_reg;
        vidx_next       = vidx_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        level_next      = level_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        speaker_next    = speaker_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                vidx_next       = '0;
                dup_next        = 1'b0;
                free_found_next = 1'b0;
                level_next      = 1'b0;
                if (accept) begin
                    case (s_tuser)
                        FUNC_TICK:     state_next = ST_TICK;
                        FUNC_NOTE_ON:  state_next = (s_tdata[6:0] != '0) ? ST_SCAN : ST_IDLE;
                        FUNC_NOTE_OFF: state_next = (s_tdata[6:0] != '0) ? ST_OFF : ST_IDLE;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                if (cur_note != '0 && cur_high) begin
                    level_next = 1'b1;
                end
                vidx_next = vidx_reg + VW'(1);
                if (last_voice) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    speaker_next = level_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (cur_note == note_reg) begin
                    dup_next = 1'b1;
                end
                if (cur_note == '0 && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = vidx_reg;
                end
                vidx_next = vidx_reg + VW'(1);
                quot_next = period_reg;
                rem_next  = '0;
                cnt_next  = '0;
                if (last_voice) begin
                    state_next = (!dup_next && free_found_next) ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? DIV_W'(rem_shift - {1'b0, div_eff}) : rem_shift[DIV_W-1:0];
                quot_next = {quot_reg[PERIOD_W-2:0], q_bit};
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_IDLE;
                end
            end
            ST_OFF: begin
                vidx_next = vidx_reg + VW'(1);
                if (last_voice) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            divisor_reg    <= DUTY_DIVISOR_RESET;
            vidx_reg       <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            level_reg      <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                voice_note_reg[v] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            vidx_reg       <= vidx_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            level_reg      <= level_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                divisor_reg <= cfg_wdata;
            end
            if (write_off) begin
                voice_note_reg[vidx_reg] <= '0;
            end
            if (write_on) begin
                voice_note_reg[free_idx_reg] <= note_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        speaker_reg <= speaker_next;
        if (accept) begin
            note_reg   <= s_tdata[6:0];
            period_reg <= s_tdata[22:7];
        end
        if (write_tick) begin
            voice_phase_reg[vidx_reg] <= phase_wrap;
        end
        if (write_on) begin
            voice_period_reg[free_idx_reg] <= period_reg;
            voice_duty_reg[free_idx_reg]   <= quot_next;
            voice_phase_reg[free_idx_reg]  <= '0;
        end
    end

`ifndef SYNTHESIS
    a_tick_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == FUNC_TICK) |=> (state_reg == ST_TICK && vidx_reg == '0))
        else $error("tick beat did not start the voice sweep");

    a_div_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (free_found_reg && !dup_reg))
        else $error("divider runs without a free voice");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && speaker_reg == $past(level_reg)))
        else $error("tick result not loaded into the output register");

    a_no_result_off_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && state_reg != ST_DONE) |=> !m_valid_reg)
        else $error("result beat appeared without a tick");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psvs_pkg::*;

    localparam int VOICES      = VOICES_DEFAULT;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 2 * (VOICES + 17);
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_LIGHT,
        RX_BURSTY
    } rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = FUNC_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [DIV_W-1:0]      cfg_wdata = '0;

    polyphonic_square_voice_synth_core #(
        .VOICES(VOICES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the voice pool.
    logic [DIV_W-1:0]    duty_div;
    logic [NOTE_W-1:0]   pool_note   [VOICES];
    logic [PERIOD_W-1:0] pool_period [VOICES];
    logic [PERIOD_W-1:0] pool_duty   [VOICES];
    logic [PERIOD_W-1:0] pool_phase  [VOICES];

    logic level_q [$];

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  burst_left   = 0;
    bit  gaps_on      = 1'b0;
    int  ticks_sent   = 0;
    int  ons_sent     = 0;
    int  offs_sent    = 0;
    int  ignored_sent = 0;
    int  high_levels  = 0;
    int  div_writes   = 0;
    logic want_level;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    task automatic clear_pool();
        duty_div = DUTY_DIVISOR_RESET;
        for (int v = 0; v < VOICES; v++) begin
            pool_note[v]   = '0;
            pool_period[v] = '0;
            pool_duty[v]   = '0;
            pool_phase[v]  = '0;
        end
    endtask

    task automatic track_voices(input func_t f, input logic [NOTE_W-1:0] n,
                                input logic [PERIOD_W-1:0] p);
        logic                level;
        logic                held;
        int                  slot;
        logic [PERIOD_W:0]   nxt;
        logic [PERIOD_W-1:0] dv;
        level = 1'b0;
        held  = 1'b0;
        slot  = -1;
        case (f)
            FUNC_TICK: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (pool_note[v] != '0) begin
                        if (pool_phase[v] < pool_duty[v]) level = 1'b1;
                        nxt = {1'b0, pool_phase[v]} + 1'b1;
                        if (nxt >= {1'b0, pool_period[v]}) nxt = '0;
                        pool_phase[v] = nxt[PERIOD_W-1:0];
                    end
                end
                level_q.push_back(level);
            end
            FUNC_NOTE_ON: begin
                if (n != '0) begin
                    for (int v = 0; v < VOICES; v++) begin
                        if (pool_note[v] == n) held = 1'b1;
                        if (slot < 0 && pool_note[v] == '0) slot = v;
                    end
                    if (!held && slot >= 0) begin
                        dv = (duty_div == '0) ? PERIOD_W'(1) : PERIOD_W'(duty_div);
                        pool_note[slot]   = n;
                        pool_period[slot] = p;
                        pool_duty[slot]   = p / dv;
                        pool_phase[slot]  = '0;
                    end
                end
            end
            FUNC_NOTE_OFF: begin
                if (n != '0) begin
                    for (int v = 0; v < VOICES; v++) begin
                        if (pool_note[v] == n) begin
                            pool_note[v]   = '0;
                            pool_period[v] = '0;
                            pool_duty[v]   = '0;
                            pool_phase[v]  = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input func_t f, input logic [NOTE_W-1:0] n,
                             input logic [PERIOD_W-1:0] p);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, p, n};
        do @(posedge aclk); while (!s_tready);
        track_voices(f, n, p);
        case (f)
            FUNC_TICK:     ticks_sent++;
            FUNC_NOTE_ON:  ons_sent++;
            FUNC_NOTE_OFF: offs_sent++;
            default:       ignored_sent++;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_duty_divisor(input logic [DIV_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        duty_div = value;
        div_writes++;
    endtask

    task automatic random_beat(output bit counted);
        int                  r;
        func_t               f;
        logic [NOTE_W-1:0]   n;
        logic [PERIOD_W-1:0] p;
        r = $urandom_range(0, 99);
        if (r < 55)      f = FUNC_TICK;
        else if (r < 78) f = FUNC_NOTE_ON;
        else if (r < 95) f = FUNC_NOTE_OFF;
        else             f = FUNC_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 85) n = NOTE_W'($urandom_range(1, 6));
        else        n = NOTE_W'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 70)      p = PERIOD_W'($urandom_range(1, 24));
        else if (r < 90) p = PERIOD_W'($urandom_range(0, 255));
        else             p = PERIOD_W'($urandom());
        send_beat(f, n, p);
        counted = (f != FUNC_UNUSED);
    endtask

    task automatic test_directed();
        gaps_on = 1'b0;
        send_beat(FUNC_TICK,     7'd0,   16'd0);
        send_beat(FUNC_NOTE_ON,  7'd127, 16'hFFFF);
        send_beat(FUNC_TICK,     7'd0,   16'd0);
        send_beat(FUNC_NOTE_ON,  7'd127, 16'd5);
        send_beat(FUNC_NOTE_ON,  7'd0,   16'd10);
        send_beat(FUNC_NOTE_OFF, 7'd0,   16'd0);
        send_beat(FUNC_NOTE_ON,  7'd1,   16'd1);
        send_beat(FUNC_NOTE_ON,  7'd2,   16'd0);
        send_beat(FUNC_NOTE_ON,  7'd64,  16'd3);
        send_beat(FUNC_NOTE_ON,  7'd100, 16'd4);
        repeat (3) send_beat(FUNC_TICK, 7'd0, 16'd0);
        send_beat(FUNC_NOTE_OFF, 7'd127, 16'd0);
        repeat (3) send_beat(FUNC_TICK, 7'd0, 16'd0);
        send_beat(FUNC_UNUSED,   7'd127, 16'hFFFF);
        send_beat(FUNC_NOTE_OFF, 7'd2,   16'd0);
        send_beat(FUNC_NOTE_OFF, 7'd1,   16'd0);
        send_beat(FUNC_NOTE_OFF, 7'd64,  16'd0);
        send_beat(FUNC_NOTE_OFF, 7'd99,  16'd0);
        send_beat(FUNC_TICK,     7'd0,   16'd0);
    endtask

    task automatic test_divisor_sweep();
        logic [DIV_W-1:0] settings [4];
        settings[0] = 8'd1;
        settings[1] = 8'd255;
        settings[2] = 8'd0;
        settings[3] = 8'd7;
        gaps_on = 1'b1;
        foreach (settings[i]) begin
            set_duty_divisor(settings[i]);
            send_beat(FUNC_NOTE_ON, 7'd10, 16'd255);
            send_beat(FUNC_NOTE_ON, 7'd11, 16'd60);
            repeat (6) send_beat(FUNC_TICK, 7'd0, 16'd0);
            send_beat(FUNC_NOTE_OFF, 7'd10, 16'd0);
            send_beat(FUNC_NOTE_OFF, 7'd11, 16'd0);
            send_beat(FUNC_TICK, 7'd0, 16'd0);
        end
    endtask

    task automatic test_random();
        int phase_items;
        bit counted;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_duty_divisor(8'd2);
                1:       set_duty_divisor(8'd255);
                2:       set_duty_divisor(8'd1);
                default: set_duty_divisor(DIV_W'($urandom_range(3, 16)));
            endcase
            gaps_on     = (ph != 0);
            phase_items = 0;
            while (phase_items < 80) begin
                random_beat(counted);
                if (counted) phase_items++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= 64;
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= ($urandom_range(0, 1) != 0);
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            default:  m_tready <= ((rx_left % 8) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (level_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("Unexpected output beat: got %h, none expected", m_tdata);
                mismatches++;
            end else begin
                want_level = level_q.pop_front();
                if (want_level) high_levels++;
                if (m_tdata !== {{(M_DATA_W-1){1'b0}}, want_level}) begin
                    if (mismatches < MAX_REPORTS)
                        $display("Speaker mismatch: expected %0d, got %h", want_level, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without a beat.", quiet_cycles);
            $display("[polyphonic_square_voice_synth_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_pool();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_divisor_sweep();
        test_random();
        drain();
        if (level_q.size() != 0) mismatches++;
        $display("Covered %0d ticks (%0d high), %0d note-ons, %0d note-offs and %0d ignored beats",
                 ticks_sent, high_levels, ons_sent, offs_sent, ignored_sent);
        $display("across %0d divisor writes, with %0d mismatches.", div_writes, mismatches);
        if (mismatches == 0) begin
            $display("[polyphonic_square_voice_synth_core] OK");
        end else begin
            $display("[polyphonic_square_voice_synth_core] ERROR");
        end
        $finish;
    end
endmodule

@@ polyphonic_square_voice_synth_core.f @@
sv/psvs_pkg.sv
sv/polyphonic_square_voice_synth_core.sv
verif/tb_top.sv
